// ----- design/streaming_mean_variance_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Streaming mean and variance assertion macros
// Shared property forms for the checker of the streaming mean/variance unit.
// ----------------------------------------------------------------------------
`ifndef STREAMING_MEAN_VARIANCE_UNIT_MACROS_SVH
`define STREAMING_MEAN_VARIANCE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SMV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("streaming mean/variance check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SMV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("streaming mean/variance check failed");

`endif

// ----- design/smv_pkg.sv -----
// ----------------------------------------------------------------------------
// Streaming mean and variance package
// Widths, status codes and sequencer states shared by the unit and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smv_pkg;

  localparam int SMP_W  = 16;
  localparam int CNT_W  = 17;
  localparam int SUM_W  = 33;
  localparam int SQ_W   = 47;
  localparam int MAG_W  = 32;
  localparam int PROD_W = 64;
  localparam int DEN_W  = 33;
  localparam int VAR_W  = 32;
  localparam int ITER_W = 6;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_FEW = 2'd1;
  localparam status_t ST_OVF = 2'd2;

  typedef enum logic [3:0] {
    S_ACC,
    S_SETUP,
    S_MEAN_DIV,
    S_MEAN_FIX,
    S_MUL_DEN,
    S_MUL_N_S2,
    S_MUL_SQ,
    S_SUB,
    S_DIV_VAR,
    S_DONE
  } state_t;

endpackage

// ----- design/streaming_mean_variance_unit.sv -----
// A sample that is not last is taken one sample per cycle while the sequencer is idle.
// A last beat starts the shared 65-bit add/subtract unit after a setup step: 32 mean
// division steps, 16 + 17 + 32 multiply steps and 64 variance division steps, or only
// the mean division steps when the status is not OK.
// The input is stalled while the sequencer runs; the result sits in an output register.
// Reset (rst_n, synchronous, active low) clears the accumulators and the sequencer.
// ----------------------------------------------------------------------------
// Streaming mean and variance unit
// Accumulates count, sum and sum of squares, then derives the floor mean and
// the unbiased variance with one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module streaming_mean_variance_unit #(
  parameter int MAX_COUNT    = 65536,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [smv_pkg::SMP_W-1:0] in_sample,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [smv_pkg::SMP_W-1:0] out_mean,
  output logic [smv_pkg::VAR_W-1:0]    out_variance,
  output logic [smv_pkg::CNT_W-1:0]    out_count,
  output smv_pkg::status_t             out_status
);

  import smv_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COUNT);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         n_r, n_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic                     ovf_r, ovf_nxt;

  logic [PROD_W-1:0]        acc_r, acc_nxt;
  logic [PROD_W-1:0]        opa_r, opa_nxt;
  logic [MAG_W-1:0]         opb_r, opb_nxt;
  logic [PROD_W-1:0]        p1_r, p1_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt;
  logic [SMP_W-1:0]         mean_r, mean_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]         out_mean_r;
  logic [VAR_W-1:0]         out_variance_r;
  logic [CNT_W-1:0]         out_count_r;
  status_t                  out_status_r;

  logic                     in_fire;
  logic                     out_free;
  logic signed [SMP_W-1:0]  smp;
  logic signed [2*SMP_W-1:0] smp_sq;
  logic                     sum_neg;
  logic [MAG_W-1:0]         sum_mag;
  status_t                  status;

  logic [PROD_W-1:0]        add_a;
  logic [PROD_W-1:0]        add_b;
  logic                     add_sub;
  logic [PROD_W:0]          add_sum;
  logic [DEN_W:0]           div_shift;
  logic                     div_ge;
  logic [DEN_W-1:0]         rem_step;

  assign smp     = SMP_W'($signed(in_sample[SAMPLE_WIDTH-1:0]));
  assign smp_sq  = smp * smp;
  assign in_fire = in_valid && !in_stall;
  assign sum_neg = sum_r[SUM_W-1];
  assign sum_mag = sum_neg ? MAG_W'(-sum_r) : sum_r[MAG_W-1:0];

  always_comb begin
    if (ovf_r) begin
      status = ST_OVF;
    end else if (n_r < CNT_W'(2)) begin
      status = ST_FEW;
    end else begin
      status = ST_OK;
    end
  end

  // Shared add/subtract unit: multiply steps add, division steps trial-subtract.
  assign div_shift = {rem_r, acc_r[PROD_W-1]};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_MEAN_DIV, S_DIV_VAR: begin
        add_a   = PROD_W'(div_shift);
        add_b   = PROD_W'(den_r);
        add_sub = 1'b1;
      end
      S_MUL_DEN, S_MUL_N_S2, S_MUL_SQ: begin
        add_a = acc_r;
        add_b = opb_r[0] ? opa_r : '0;
      end
      S_SUB: begin
        add_a   = p1_r;
        add_b   = acc_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum  = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (PROD_W + 1)'(add_sub);
  assign div_ge   = add_sum[PROD_W];
  assign rem_step = div_ge ? add_sum[DEN_W-1:0] : div_shift[DEN_W-1:0];

  // Output-side control.
  always_comb begin
    in_stall = (state_r != S_ACC);
    out_free = !out_valid_r || !out_stall;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_ACC:      if (in_fire && in_last) state_nxt = S_SETUP;
      S_SETUP:    state_nxt = S_MEAN_DIV;
      S_MEAN_DIV: if (cnt_r == '0) state_nxt = S_MEAN_FIX;
      S_MEAN_FIX: state_nxt = (status == ST_OK) ? S_MUL_DEN : S_DONE;
      S_MUL_DEN:  if (cnt_r == '0) state_nxt = S_MUL_N_S2;
      S_MUL_N_S2: if (cnt_r == '0) state_nxt = S_MUL_SQ;
      S_MUL_SQ:   if (cnt_r == '0) state_nxt = S_SUB;
      S_SUB:      state_nxt = S_DIV_VAR;
      S_DIV_VAR:  if (cnt_r == '0) state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_ACC;
      default:    state_nxt = S_ACC;
    endcase
  end

  // Datapath next values.
  always_comb begin
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    ovf_nxt       = ovf_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    p1_nxt        = p1_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_ACC: begin
        if (in_fire) begin
          if (n_r >= MAX_CNT) begin
            ovf_nxt = 1'b1;
          end else begin
            n_nxt   = n_r + CNT_W'(1);
            sum_nxt = sum_r + SUM_W'(smp);
            sq_nxt  = sq_r + SQ_W'($unsigned(smp_sq));
          end
        end
      end
      S_SETUP: begin
        acc_nxt = {sum_mag, {(PROD_W - MAG_W){1'b0}}};
        rem_nxt = '0;
        den_nxt = DEN_W'(n_r);
        cnt_nxt = ITER_W'(MAG_W - 1);
      end
      S_MEAN_DIV, S_DIV_VAR: begin
        acc_nxt = {acc_r[PROD_W-2:0], div_ge};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - ITER_W'(1);
      end
      S_MEAN_FIX: begin
        mean_nxt = sum_neg ? (SMP_W'(0) - acc_r[SMP_W-1:0] - SMP_W'(rem_r != '0))
                           : acc_r[SMP_W-1:0];
        acc_nxt  = '0;
        opa_nxt  = PROD_W'(n_r);
        opb_nxt  = MAG_W'(n_r - CNT_W'(1));
        cnt_nxt  = ITER_W'(CNT_W - 2);
      end
      S_MUL_DEN, S_MUL_N_S2, S_MUL_SQ: begin
        acc_nxt = add_sum[PROD_W-1:0];
        opa_nxt = {opa_r[PROD_W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[MAG_W-1:1]};
        cnt_nxt = cnt_r - ITER_W'(1);
        if (cnt_r == '0) begin
          if (state_r == S_MUL_DEN) begin
            den_nxt = add_sum[DEN_W-1:0];
            acc_nxt = '0;
            opa_nxt = PROD_W'(sq_r);
            opb_nxt = MAG_W'(n_r);
            cnt_nxt = ITER_W'(CNT_W - 1);
          end else if (state_r == S_MUL_N_S2) begin
            p1_nxt  = add_sum[PROD_W-1:0];
            acc_nxt = '0;
            opa_nxt = PROD_W'(sum_mag);
            opb_nxt = sum_mag;
            cnt_nxt = ITER_W'(MAG_W - 1);
          end
        end
      end
      S_SUB: begin
        acc_nxt = add_sum[PROD_W-1:0];
        rem_nxt = '0;
        cnt_nxt = ITER_W'(PROD_W - 1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          n_nxt         = '0;
          sum_nxt       = '0;
          sq_nxt        = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      n_r         <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      ovf_r       <= ovf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    p1_r   <= p1_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    mean_r <= mean_nxt;
    if (state_r == S_DONE && out_free) begin
      out_mean_r     <= mean_r;
      out_variance_r <= (status == ST_OK) ? acc_r[VAR_W-1:0] : '0;
      out_count_r    <= n_r;
      out_status_r   <= status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mean     = out_mean_r;
  assign out_variance = out_variance_r;
  assign out_count    = out_count_r;
  assign out_status   = out_status_r;

endmodule

// ----- design/smv_chk.sv -----
// ----------------------------------------------------------------------------
// Streaming mean and variance checker
// Port-level checks on the unit's handshakes and result fields, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "streaming_mean_variance_unit_macros.svh"

module smv_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [smv_pkg::SMP_W-1:0]     out_mean,
  input logic [smv_pkg::VAR_W-1:0]     out_variance,
  input logic [smv_pkg::CNT_W-1:0]     out_count,
  input smv_pkg::status_t              out_status
);

  import smv_pkg::*;

  logic                               last_beat;
  logic [SMP_W+VAR_W+CNT_W+1:0]       result_bits;

  assign last_beat   = in_valid && !in_stall && in_last;
  assign result_bits = {out_mean, out_variance, out_count, out_status};

  `SMV_ASSERT_NEXT(a_stall_after_last, last_beat, in_stall)
  `SMV_ASSERT_SAME(a_error_zero_variance, out_valid && (out_status != ST_OK), out_variance == '0)
  `SMV_ASSERT_SAME(a_few_is_one, out_valid && (out_status == ST_FEW), out_count == CNT_W'(1))
  `SMV_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(result_bits))

endmodule

bind streaming_mean_variance_unit smv_chk u_smv_chk (.*);
